// ===== rtl/vmt_pkg.sv =====
// Package with the types, constants and helpers of the 4x4 vector-matrix transform.
`default_nettype none

package vmt_pkg;

  localparam int ELEMENT_BITS  = 16;
  localparam int COEF_BITS     = 16;
  localparam int FRAC_SHIFT    = 12;
  localparam int NUM_ELEM      = 4;
  localparam int ROW_BITS      = NUM_ELEM * COEF_BITS;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = ROW_BITS;
  localparam int PROD_BITS     = ELEMENT_BITS + COEF_BITS;
  localparam int SUM_BITS      = PROD_BITS + 2;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_MATRIX_ROW0 = 3'd0,
    REG_MATRIX_ROW1 = 3'd1,
    REG_MATRIX_ROW2 = 3'd2,
    REG_MATRIX_ROW3 = 3'd3
  } cfg_reg_t;

  localparam cfg_reg_t ROW_REG [NUM_ELEM] = '{
    REG_MATRIX_ROW0, REG_MATRIX_ROW1, REG_MATRIX_ROW2, REG_MATRIX_ROW3
  };

  typedef logic signed [ELEMENT_BITS-1:0] elem_t;
  typedef logic signed [COEF_BITS-1:0]    coef_t;
  typedef logic signed [PROD_BITS-1:0]    prod_t;
  typedef logic signed [SUM_BITS-1:0]     sum_t;

  typedef elem_t [NUM_ELEM-1:0] elem_vec_t;
  typedef prod_t [NUM_ELEM-1:0] prod_vec_t;
  typedef sum_t  [NUM_ELEM-1:0] sum_vec_t;

  typedef struct packed {
    logic signed [ELEMENT_BITS-1:0] in_x;
    logic signed [ELEMENT_BITS-1:0] in_y;
    logic signed [ELEMENT_BITS-1:0] in_z;
    logic signed [ELEMENT_BITS-1:0] in_w;
  } in_t;

  typedef struct packed {
    logic signed [ELEMENT_BITS-1:0] out_x;
    logic signed [ELEMENT_BITS-1:0] out_y;
    logic signed [ELEMENT_BITS-1:0] out_z;
    logic signed [ELEMENT_BITS-1:0] out_w;
    logic                           clipped;
  } out_t;

  typedef struct packed {
    logic                we;
    logic [ROW_BITS-1:0] data;
  } row_wr_t;

  function automatic logic [ROW_BITS-1:0] identity_row(input int k);
    logic [ROW_BITS-1:0] row;
    row = '0;
    row[k*COEF_BITS +: COEF_BITS] = COEF_BITS'(1 << FRAC_SHIFT);
    return row;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/vmt_cell.sv =====
// One cell of the transform chain: holds one matrix row and adds its products.
`default_nettype none

module vmt_cell (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire vmt_pkg::row_wr_t           row_wr,
  input  wire logic [vmt_pkg::ROW_BITS-1:0] row_init,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire vmt_pkg::elem_vec_t         in_vec,
  input  wire vmt_pkg::sum_vec_t          in_psum,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output vmt_pkg::elem_vec_t              out_vec,
  output vmt_pkg::sum_vec_t               out_psum
);

  logic [vmt_pkg::ROW_BITS-1:0] row_r;

  logic                a_valid_r;
  vmt_pkg::elem_vec_t  a_vec_r;
  vmt_pkg::sum_vec_t   a_psum_r;
  vmt_pkg::prod_vec_t  a_prod_r;
  vmt_pkg::prod_vec_t  a_prod_nxt;

  logic                b_valid_r;
  vmt_pkg::elem_vec_t  b_vec_r;
  vmt_pkg::sum_vec_t   b_psum_r;
  vmt_pkg::sum_vec_t   b_psum_nxt;

  logic a_ready;
  logic b_ready;

  assign b_ready  = !b_valid_r || out_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign in_ready = a_ready;

  always_comb begin
    for (int j = 0; j < vmt_pkg::NUM_ELEM; j++) begin
      a_prod_nxt[j] = vmt_pkg::PROD_BITS'($signed(in_vec[0]) *
                      $signed(row_r[j*vmt_pkg::COEF_BITS +: vmt_pkg::COEF_BITS]));
      b_psum_nxt[j] = $signed(a_psum_r[j]) +
                      vmt_pkg::SUM_BITS'($signed(a_prod_r[j]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r     <= row_init;
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (row_wr.we) begin
        row_r <= row_wr.data;
      end
      if (a_ready) begin
        a_valid_r <= in_valid;
      end
      if (b_ready) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_ready) begin
      a_vec_r  <= {vmt_pkg::elem_t'(0), in_vec[vmt_pkg::NUM_ELEM-1:1]};
      a_psum_r <= in_psum;
      a_prod_r <= a_prod_nxt;
    end
    if (a_valid_r && b_ready) begin
      b_vec_r  <= a_vec_r;
      b_psum_r <= b_psum_nxt;
    end
  end

  assign out_valid = b_valid_r;
  assign out_vec   = b_vec_r;
  assign out_psum  = b_psum_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r && !out_ready |=> b_valid_r && $stable(b_psum_r))
    else $error("cell result changed while stalled");

  a_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    !a_valid_r |-> in_ready)
    else $error("cell refused a request with an empty first stage");

  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> a_valid_r)
    else $error("accepted request lost in cell");

endmodule

`default_nettype wire

// ===== rtl/vmt_sat.sv =====
// Output stage: rounds, saturates and registers the four column sums.
`default_nettype none

module vmt_sat (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire vmt_pkg::sum_vec_t in_psum,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output vmt_pkg::out_t          out_data
);

  localparam int E    = vmt_pkg::ELEMENT_BITS;
  localparam int BW   = vmt_pkg::SUM_BITS + 1;
  localparam int SH_W = BW - vmt_pkg::FRAC_SHIFT;

  localparam longint HI_L = (longint'(1) <<< (E - 1)) - 1;
  localparam longint LO_L = -(longint'(1) <<< (E - 1));
  localparam logic signed [SH_W-1:0] HI_S = SH_W'(HI_L);
  localparam logic signed [SH_W-1:0] LO_S = SH_W'(LO_L);
  localparam logic signed [E-1:0]    HI_E = E'(HI_L);
  localparam logic signed [E-1:0]    LO_E = E'(LO_L);
  localparam logic signed [BW-1:0]   HALF = BW'(1 << (vmt_pkg::FRAC_SHIFT - 1));

  logic               out_valid_r;
  vmt_pkg::out_t      out_data_r;
  vmt_pkg::out_t      out_data_nxt;
  vmt_pkg::elem_vec_t res;

  always_comb begin
    logic signed [BW-1:0]   biased;
    logic signed [SH_W-1:0] shifted;
    logic                   clip;
    clip = 1'b0;
    for (int j = 0; j < vmt_pkg::NUM_ELEM; j++) begin
      biased  = BW'($signed(in_psum[j])) + HALF;
      shifted = SH_W'(biased >>> vmt_pkg::FRAC_SHIFT);
      if (shifted > HI_S) begin
        res[j] = HI_E;
        clip   = 1'b1;
      end else if (shifted < LO_S) begin
        res[j] = LO_E;
        clip   = 1'b1;
      end else begin
        res[j] = E'(shifted);
      end
    end
    out_data_nxt.out_x   = res[0];
    out_data_nxt.out_y   = res[1];
    out_data_nxt.out_z   = res[2];
    out_data_nxt.out_w   = res[3];
    out_data_nxt.clipped = clip;
  end

  assign in_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.clipped |->
      out_data_r.out_x == HI_E || out_data_r.out_x == LO_E ||
      out_data_r.out_y == HI_E || out_data_r.out_y == LO_E ||
      out_data_r.out_z == HI_E || out_data_r.out_z == LO_E ||
      out_data_r.out_w == HI_E || out_data_r.out_w == LO_E)
    else $error("clipped flag set without a saturated element");

endmodule

`default_nettype wire

// ===== rtl/vector_matrix_transform_4x4.sv =====
// Top level of the 4x4 vector-matrix transform: a chain of four row cells.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   in_data   (vmt_pkg::in_t)
//   out_     output     out_valid / out_ready out_data  (vmt_pkg::out_t)
//   cfg_     input      cfg_we                cfg_index, cfg_data
//
// One request is taken per clock cycle while in_ready is high; a result passes
// two registers in each row cell and one in the rounding and saturation stage.
// Each cell stage carries its own valid bit, so empty stages keep accepting
// requests while a finished result waits for out_ready.
// Reset clears all valid bits and loads the identity matrix into the cells.
`default_nettype none

module vector_matrix_transform_4x4 (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire vmt_pkg::in_t                      in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output vmt_pkg::out_t                          out_data,
  input  wire logic                              cfg_we,
  input  wire logic [vmt_pkg::CFG_ADDR_BITS-1:0] cfg_index,
  input  wire logic [vmt_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  localparam int N = vmt_pkg::NUM_ELEM;

  logic               valid_c [N+1];
  logic               ready_c [N+1];
  vmt_pkg::elem_vec_t vec_c   [N+1];
  vmt_pkg::sum_vec_t  psum_c  [N+1];
  vmt_pkg::row_wr_t   row_wr  [N];

  assign valid_c[0] = in_valid;
  assign in_ready   = ready_c[0];
  assign vec_c[0]   = {in_data.in_w, in_data.in_z, in_data.in_y, in_data.in_x};
  assign psum_c[0]  = '0;

  for (genvar k = 0; k < N; k++) begin : g_cell
    assign row_wr[k].we   = cfg_we && (cfg_index == vmt_pkg::ROW_REG[k]);
    assign row_wr[k].data = cfg_data;

    vmt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .row_wr    (row_wr[k]),
      .row_init  (vmt_pkg::identity_row(k)),
      .in_valid  (valid_c[k]),
      .in_ready  (ready_c[k]),
      .in_vec    (vec_c[k]),
      .in_psum   (psum_c[k]),
      .out_valid (valid_c[k+1]),
      .out_ready (ready_c[k+1]),
      .out_vec   (vec_c[k+1]),
      .out_psum  (psum_c[k+1])
    );
  end

  vmt_sat u_sat (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (valid_c[N] && (vec_c[N] == '0 || vec_c[N] != '0)),
    .in_ready  (ready_c[N]),
    .in_psum   (psum_c[N]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
